// File: rtl/core/csq_pkg.sv
`default_nettype none

package csq_pkg;

  // Default sizing of the waiter queue and of thread ids.
  localparam int unsigned MAX_WAITERS_DEF    = 16;
  localparam int unsigned THREAD_ID_BITS_DEF = 8;

  // Count register: signed, wide enough for twice the largest initial count.
  localparam int unsigned COUNT_W   = 18;
  localparam int unsigned INIT_W    = 16;
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 18'sd131071;

  typedef enum logic [1:0] {
    OP_WAIT     = 2'd0,
    OP_SIGNAL   = 2'd1,
    OP_TRY_WAIT = 2'd2,
    OP_CLOSE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_BLOCKED     = 3'd1,
    STAT_CLOSED      = 3'd2,
    STAT_WOULD_BLOCK = 3'd3,
    STAT_QUEUE_FULL  = 3'd4,
    STAT_SATURATED   = 3'd5
  } status_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  // Per-cell control from the sequencer to the queue chain.
  typedef struct packed {
    logic shift;  // take the neighbor's entry (pop at the head)
    logic load;   // take the pushed thread id
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/counting_semaphore_with_wait_queue.sv
`default_nettype none

// Channel  | Direction | Handshake              | Beat contents
// ---------+-----------+------------------------+----------------------------------------
// in_      | input     | in_valid / in_ready    | operation, thread id
// out_     | output    | out_valid / out_ready  | status, released valid/thread, last
// cfg_     | input     | cfg_valid / cfg_ready  | initial count (reloads the semaphore)
//
// Wait, signal and try-wait each give one result beat, which is registered and
// offered the cycle after the request beat is accepted. Close with N > 0 waiters
// gives N beats, one per cycle while out_ready is high, and holds off new requests
// until the last one is loaded. A stalled out_ready keeps the pending beat in the
// output register and blocks in_ready through it; nothing is dropped. Synchronous
// active-low reset clears count, closed flag, occupancy, sequencer and output valid.
module counting_semaphore_with_wait_queue #(
  parameter int unsigned MAX_WAITERS    = csq_pkg::MAX_WAITERS_DEF,
  parameter int unsigned THREAD_ID_BITS = csq_pkg::THREAD_ID_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,

  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_operation,
  input  wire logic [THREAD_ID_BITS-1:0]  in_thread_id,

  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [2:0]                      out_status,
  output logic                            out_released_valid,
  output logic [THREAD_ID_BITS-1:0]       out_released_thread,
  output logic                            out_last,

  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [csq_pkg::INIT_W-1:0] cfg_initial_count
);

  // Occupancy must represent every value from empty to completely full.
  localparam int unsigned OCC_W = $clog2(MAX_WAITERS + 1);

  // Architectural state.
  logic signed [csq_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                               closed_r, closed_nxt;
  logic [OCC_W-1:0]                   occ_r, occ_nxt;
  csq_pkg::state_t                    state_r, state_nxt;

  // Output register.
  logic                      out_valid_r, out_valid_nxt;
  csq_pkg::status_t          out_status_r;
  logic                      out_rel_valid_r;
  logic [THREAD_ID_BITS-1:0] out_rel_thread_r;
  logic                      out_last_r;

  // Result being formed this cycle.
  logic                      res_load;
  csq_pkg::status_t          res_status;
  logic                      res_rel;
  logic                      res_last;

  logic                      slot_free;
  logic                      accept;
  logic                      drain_fire;
  logic                      cfg_write;
  logic                      push;
  logic                      pop;
  csq_pkg::op_t              op;

  logic [THREAD_ID_BITS-1:0] cell_data [MAX_WAITERS];
  csq_pkg::cell_ctrl_t       cell_ctrl [MAX_WAITERS];

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign op        = csq_pkg::op_t'(in_operation);

  // Sequencer outputs: the request port opens only in the idle state, and a
  // drain step fires whenever the output register can take a beat.
  always_comb begin
    in_ready   = 1'b0;
    drain_fire = 1'b0;
    unique case (state_r)
      csq_pkg::ST_IDLE: begin
        in_ready = slot_free;
      end
      csq_pkg::ST_DRAIN: begin
        drain_fire = slot_free;
      end
      default: begin
        in_ready   = 1'b0;
        drain_fire = 1'b0;
      end
    endcase
  end

  assign accept = in_valid & in_ready;

  // Sequencer next state: a close with more than one waiter keeps draining
  // until the beat for the final waiter has been loaded.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csq_pkg::ST_IDLE: begin
        if (accept && !closed_r && op == csq_pkg::OP_CLOSE &&
            occ_r > OCC_W'(1)) begin
          state_nxt = csq_pkg::ST_DRAIN;
        end
      end
      csq_pkg::ST_DRAIN: begin
        if (drain_fire && occ_r == OCC_W'(1)) begin
          state_nxt = csq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = csq_pkg::ST_IDLE;
      end
    endcase
  end

  // Semaphore datapath. The user must write the configuration only while the block
  // is idle; the block does not enforce it, and a write simply overrides anything else.
  always_comb begin
    count_nxt  = count_r;
    closed_nxt = closed_r;
    occ_nxt    = occ_r;
    push       = 1'b0;
    pop        = 1'b0;
    res_load   = 1'b0;
    res_status = csq_pkg::STAT_OK;
    res_rel    = 1'b0;
    res_last   = 1'b1;
    if (cfg_write) begin
      count_nxt  = csq_pkg::COUNT_W'(cfg_initial_count);
      closed_nxt = 1'b0;
      occ_nxt    = '0;
    end else if (drain_fire) begin
      pop      = 1'b1;
      occ_nxt  = occ_r - OCC_W'(1);
      res_load = 1'b1;
      res_rel  = 1'b1;
      res_last = (occ_r == OCC_W'(1));
    end else if (accept) begin
      res_load = 1'b1;
      if (closed_r) begin
        res_status = csq_pkg::STAT_CLOSED;
      end else begin
        unique case (op)
          csq_pkg::OP_WAIT: begin
            if (count_r <= 18'sd0) begin
              // The caller would block; it needs a free queue slot.
              if (occ_r == OCC_W'(MAX_WAITERS)) begin
                res_status = csq_pkg::STAT_QUEUE_FULL;
              end else begin
                count_nxt  = count_r - 18'sd1;
                push       = 1'b1;
                occ_nxt    = occ_r + OCC_W'(1);
                res_status = csq_pkg::STAT_BLOCKED;
              end
            end else begin
              count_nxt = count_r - 18'sd1;
            end
          end
          csq_pkg::OP_SIGNAL: begin
            if (count_r >= csq_pkg::COUNT_MAX) begin
              res_status = csq_pkg::STAT_SATURATED;
            end else begin
              count_nxt = count_r + 18'sd1;
              // The raised count is still not positive: hand the unit to
              // the oldest waiter.
              if (count_r < 18'sd0 && occ_r != '0) begin
                pop     = 1'b1;
                occ_nxt = occ_r - OCC_W'(1);
                res_rel = 1'b1;
              end
            end
          end
          csq_pkg::OP_TRY_WAIT: begin
            if (count_r > 18'sd0) begin
              count_nxt = count_r - 18'sd1;
            end else begin
              res_status = csq_pkg::STAT_WOULD_BLOCK;
            end
          end
          csq_pkg::OP_CLOSE: begin
            closed_nxt = 1'b1;
            // The first waiter leaves in the same cycle; the rest drain.
            if (occ_r != '0) begin
              pop      = 1'b1;
              occ_nxt  = occ_r - OCC_W'(1);
              res_rel  = 1'b1;
              res_last = (occ_r == OCC_W'(1));
            end
          end
          default: begin
            res_status = csq_pkg::STAT_OK;
          end
        endcase
      end
    end
  end

  // Waiter queue as a chain of cells. Pops shift every cell one step toward
  // the head; a push writes the first unoccupied cell.
  for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
    logic [THREAD_ID_BITS-1:0] shift_src;

    if (i == MAX_WAITERS - 1) begin : g_tail
      assign shift_src = '0;
    end else begin : g_mid
      assign shift_src = cell_data[i+1];
    end

    assign cell_ctrl[i].shift = pop;
    assign cell_ctrl[i].load  = push && (occ_r == OCC_W'(i));

    csq_cell #(
      .WIDTH (THREAD_ID_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl[i]),
      .shift_in (shift_src),
      .load_in  (in_thread_id),
      .data_out (cell_data[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      closed_r    <= 1'b0;
      occ_r       <= '0;
      state_r     <= csq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      closed_r    <= closed_nxt;
      occ_r       <= occ_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload; the released id reads as zero unless a waiter left.
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r     <= res_status;
      out_rel_valid_r  <= res_rel;
      out_rel_thread_r <= res_rel ? cell_data[0] : '0;
      out_last_r       <= res_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_released_valid  = out_rel_valid_r;
  assign out_released_thread = out_rel_thread_r;
  assign out_last            = out_last_r;

endmodule

`default_nettype wire

// File: rtl/core/csq_cell.sv
`default_nettype none

// One slot of the waiter queue. Slot 0 is the head; on a pop every slot
// takes the entry of the slot behind it.
module csq_cell #(
  parameter int unsigned WIDTH = csq_pkg::THREAD_ID_BITS_DEF
) (
  input  wire logic                clk,
  input  wire csq_pkg::cell_ctrl_t ctrl,
  input  wire logic [WIDTH-1:0]    shift_in,
  input  wire logic [WIDTH-1:0]    load_in,
  output logic [WIDTH-1:0]         data_out
);

  logic [WIDTH-1:0] data_r;
  logic [WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift) begin
      data_nxt = shift_in;
    end else if (ctrl.load) begin
      data_nxt = load_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

`default_nettype wire

// File: tb/sv/tb_counting_semaphore_with_wait_queue.sv
`timescale 1ns / 100ps

// One expected or observed result beat of the semaphore.
typedef struct {
  csq_pkg::status_t status;
  logic             rel_valid;
  logic [7:0]       rel_thread;
  logic             last;
} sem_beat_t;

// Tracks the semaphore state and the result beats that are still owed by the block.
class semaphore_scoreboard;
  int              sem_count;
  bit              sem_closed;
  logic [7:0]      blocked_ids[$];
  sem_beat_t       owed_beats[$];
  int unsigned     mismatches;
  int unsigned     requests_seen;
  int unsigned     beats_checked;
  int unsigned     releases_seen;
  int unsigned     status_seen[6];

  function new();
    mismatches    = 0;
    requests_seen = 0;
    beats_checked = 0;
    releases_seen = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    load_initial_count(16'd0);
  endfunction

  // A register write reloads the count, reopens the semaphore and empties the queue.
  function void load_initial_count(logic [15:0] value);
    sem_count  = int'(value);
    sem_closed = 1'b0;
    blocked_ids.delete();
  endfunction

  function int unsigned pending();
    return owed_beats.size();
  endfunction

  function void owe_beat(csq_pkg::status_t st, logic rv, logic [7:0] rt, logic lst);
    sem_beat_t b;
    b.status     = st;
    b.rel_valid  = rv;
    b.rel_thread = rt;
    b.last       = lst;
    owed_beats.push_back(b);
  endfunction

  // Works out the beats that one accepted request causes.
  function void note_request(csq_pkg::op_t op, logic [7:0] id);
    logic [7:0] rel;
    requests_seen++;
    if (sem_closed) begin
      owe_beat(csq_pkg::STAT_CLOSED, 1'b0, 8'd0, 1'b1);
      return;
    end
    case (op)
      csq_pkg::OP_WAIT: begin
        if (sem_count - 1 < 0) begin
          if (blocked_ids.size() >= csq_pkg::MAX_WAITERS_DEF) begin
            owe_beat(csq_pkg::STAT_QUEUE_FULL, 1'b0, 8'd0, 1'b1);
          end else begin
            sem_count--;
            blocked_ids.push_back(id);
            owe_beat(csq_pkg::STAT_BLOCKED, 1'b0, 8'd0, 1'b1);
          end
        end else begin
          sem_count--;
          owe_beat(csq_pkg::STAT_OK, 1'b0, 8'd0, 1'b1);
        end
      end
      csq_pkg::OP_SIGNAL: begin
        if (sem_count >= int'(csq_pkg::COUNT_MAX)) begin
          owe_beat(csq_pkg::STAT_SATURATED, 1'b0, 8'd0, 1'b1);
        end else begin
          sem_count++;
          if (sem_count <= 0 && blocked_ids.size() != 0) begin
            rel = blocked_ids.pop_front();
            owe_beat(csq_pkg::STAT_OK, 1'b1, rel, 1'b1);
          end else begin
            owe_beat(csq_pkg::STAT_OK, 1'b0, 8'd0, 1'b1);
          end
        end
      end
      csq_pkg::OP_TRY_WAIT: begin
        if (sem_count > 0) begin
          sem_count--;
          owe_beat(csq_pkg::STAT_OK, 1'b0, 8'd0, 1'b1);
        end else begin
          owe_beat(csq_pkg::STAT_WOULD_BLOCK, 1'b0, 8'd0, 1'b1);
        end
      end
      default: begin
        sem_closed = 1'b1;
        if (blocked_ids.size() == 0) begin
          owe_beat(csq_pkg::STAT_OK, 1'b0, 8'd0, 1'b1);
        end else begin
          while (blocked_ids.size() != 0) begin
            rel = blocked_ids.pop_front();
            owe_beat(csq_pkg::STAT_OK, 1'b1, rel, blocked_ids.size() == 0);
          end
        end
      end
    endcase
  endfunction

  task report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Compares one accepted result beat with the oldest owed beat.
  task check_beat(logic [2:0] st, logic rv, logic [7:0] rt, logic lst);
    sem_beat_t e;
    beats_checked++;
    if (st < 3'd6) status_seen[st]++;
    if (rv === 1'b1) releases_seen++;
    if (owed_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected beat status=%0d rel=%0b/%0h last=%0b",
                                st, rv, rt, lst));
      return;
    end
    e = owed_beats.pop_front();
    if (st !== e.status || rv !== e.rel_valid || rt !== e.rel_thread || lst !== e.last)
      report_mismatch($sformatf("beat got status=%0d rel=%0b/%0h last=%0b, want %0d %0b/%0h %0b",
                                st, rv, rt, lst, e.status, e.rel_valid, e.rel_thread,
                                e.last));
  endtask
endclass

module tb_counting_semaphore_with_wait_queue;

  // Generous bound on the whole run, far above the slowest legal run.
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_ITEMS = 400;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_operation = 2'd0;
  logic [7:0] in_thread_id = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic [2:0] out_status;
  logic       out_released_valid;
  logic [7:0] out_released_thread;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [csq_pkg::INIT_W-1:0] cfg_initial_count = '0;

  // Idling switches: when clear, the corresponding side runs at full rate.
  bit          send_idle = 1'b0;
  bit          sink_idle = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;

  semaphore_scoreboard board;

  counting_semaphore_with_wait_queue u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_thread_id        (in_thread_id),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_released_valid  (out_released_valid),
    .out_released_thread (out_released_thread),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_initial_count   (cfg_initial_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The watchdog ends a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The receiver stalls at random, with lengths drawn from a short and a long range,
  // so that back pressure lands on every phase of a close drain as well as on
  // single-beat results.
  always @(negedge clk) begin
    if (!sink_idle) begin
      out_ready = 1'b1;
    end else if (stall_left != 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if ($urandom_range(0, 3) == 0)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  // Every result beat that the block hands over is checked at the edge that takes it.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_beat(out_status, out_released_valid, out_released_thread, out_last);
  end

  // Gap ahead of a request beat: mostly none or short, now and then long.
  function automatic int unsigned next_gap();
    int unsigned r;
    if (!send_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one request beat after an optional gap. The task returns at the
  // falling edge after acceptance with valid still high, so a back-to-back
  // request simply replaces the payload without a dip in valid.
  task automatic send_request(csq_pkg::op_t op, logic [7:0] id, int unsigned gap);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_operation = op;
    in_thread_id = id;
    do @(posedge clk); while (!in_ready);
    board.note_request(op, id);
    @(negedge clk);
  endtask

  // Holds the sender back until every owed beat has come out. A falling edge always
  // passes first, so valid never drops and rises within one step.
  task automatic wait_drained();
    in_valid = 1'b0;
    do @(negedge clk); while (board.pending() != 0);
  endtask

  // Register writes happen only with the block idle; a pause after the last owed
  // beat covers the tail of a close drain.
  task automatic write_initial_count(logic [15:0] value);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_valid         = 1'b1;
    cfg_initial_count = value;
    do @(posedge clk); while (!cfg_ready);
    board.load_initial_count(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int unsigned  random_sent;
    int unsigned  phase;
    int unsigned  len;
    int unsigned  r;
    logic [15:0]  init_value;
    csq_pkg::op_t op;

    board = new();

    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part, from the reset state where the count is zero. The ids
    // of all zeros and all ones exercise both extremes of the thread field.
    send_idle = 1'b1;
    sink_idle = 1'b1;
    send_request(csq_pkg::OP_TRY_WAIT, 8'h00, next_gap());  // nothing to take: would block
    send_request(csq_pkg::OP_SIGNAL,   8'hFF, next_gap());
    send_request(csq_pkg::OP_WAIT,     8'h5A, next_gap());  // takes the unit without blocking
    send_request(csq_pkg::OP_WAIT,     8'h00, next_gap());  // blocks
    send_request(csq_pkg::OP_WAIT,     8'hFF, next_gap());  // blocks
    send_request(csq_pkg::OP_SIGNAL,   8'h11, next_gap());  // releases the oldest waiter
    send_request(csq_pkg::OP_CLOSE,    8'h22, next_gap());  // releases the other one with last
    send_request(csq_pkg::OP_WAIT,     8'h33, next_gap());  // refused once closed
    send_request(csq_pkg::OP_CLOSE,    8'h44, next_gap());

    // Fill the queue to its depth, overflow it once, then close so that the
    // drain gives the longest run of beats a single request can cause.
    write_initial_count(16'd0);
    for (int i = 0; i < csq_pkg::MAX_WAITERS_DEF; i++)
      send_request(csq_pkg::OP_WAIT, 8'(i * 17), next_gap());
    send_request(csq_pkg::OP_WAIT,  8'hC3, next_gap());     // queue full
    send_request(csq_pkg::OP_CLOSE, 8'h3C, next_gap());

    // Close on an empty queue gives a single beat without a release.
    write_initial_count(16'd7);
    send_request(csq_pkg::OP_CLOSE, 8'h81, next_gap());

    // Random part. Each phase loads a count, mostly a small one so that
    // waits block and signals release, and runs a burst of requests that
    // usually ends with a close followed by a few refused requests.
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (phase)
        0: init_value = 16'd0;
        1: init_value = 16'd1;
        2: init_value = 16'hFFFF;
        3: init_value = 16'd3;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 70)      init_value = 16'($urandom_range(0, 4));
          else if (r < 85) init_value = 16'($urandom_range(5, 40));
          else             init_value = 16'($urandom_range(0, 65535));
        end
      endcase
      write_initial_count(init_value);
      send_idle = (phase % 3 != 0) && ($urandom_range(0, 3) != 0);
      sink_idle = (phase % 3 != 0) && ($urandom_range(0, 3) != 0);
      len = $urandom_range(20, 60);
      for (int k = 0; k < len && random_sent < RANDOM_ITEMS; k++) begin
        // Now and then the sender waits for the block to empty completely.
        if ((phase == 1 && k == 5) || $urandom_range(0, 24) == 0)
          wait_drained();
        r = $urandom_range(0, 99);
        if (r < 44)      op = csq_pkg::OP_WAIT;
        else if (r < 78) op = csq_pkg::OP_SIGNAL;
        else if (r < 96) op = csq_pkg::OP_TRY_WAIT;
        else             op = csq_pkg::OP_CLOSE;
        send_request(op, 8'($urandom_range(0, 255)), next_gap());
        random_sent++;
        if (op == csq_pkg::OP_CLOSE && len > k + 4)
          len = k + 1 + $urandom_range(1, 3);
      end
      phase++;
    end

    // Let the last beats out, then give the block a little longer in case
    // it emits anything that nobody asked for.
    wait_drained();
    repeat (24) @(negedge clk);

    $display("run covered %0d requests over %0d random phases and %0d result beats",
             board.requests_seen, phase, board.beats_checked);
    $display("statuses ok %0d blocked %0d closed %0d would-block %0d full %0d, %0d releases",
             board.status_seen[csq_pkg::STAT_OK], board.status_seen[csq_pkg::STAT_BLOCKED],
             board.status_seen[csq_pkg::STAT_CLOSED],
             board.status_seen[csq_pkg::STAT_WOULD_BLOCK],
             board.status_seen[csq_pkg::STAT_QUEUE_FULL], board.releases_seen);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/core/csq_pkg.sv
rtl/core/csq_cell.sv
rtl/core/counting_semaphore_with_wait_queue.sv
tb/sv/tb_counting_semaphore_with_wait_queue.sv
